FILE: rtl/q16div_pkg.sv
// Shared types and constants for the Q16.16 signed divider.
`default_nettype none

package q16div_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned GuardWidth = 7;

  localparam logic [WordWidth-1:0] TopBit    = 32'h8000_0000;
  localparam logic [WordWidth-1:0] OneWeight = 32'h0001_0000;

  typedef logic [WordWidth-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG_NUM,
    ST_MAG_DEN,
    ST_NORM,
    ST_GUARD,
    ST_DIV,
    ST_SIGN
  } state_t;

  typedef struct packed {
    logic ge;  // a >= b
    logic gt;  // a > b
  } cmp_t;

endpackage

`default_nettype wire

FILE: rtl/q16div_unit.sv
// Shared 32-bit subtract and compare unit of the divider.
`default_nettype none

module q16div_unit (
  input  wire q16div_pkg::word_t a,
  input  wire q16div_pkg::word_t b,
  output q16div_pkg::word_t      diff,
  output q16div_pkg::cmp_t       cmp
);

  logic [q16div_pkg::WordWidth:0] wide;

  // Extend by one bit so the top bit is the borrow.
  assign wide     = {1'b0, a} - {1'b0, b};
  assign diff     = wide[q16div_pkg::WordWidth-1:0];
  assign cmp.ge   = ~wide[q16div_pkg::WordWidth];
  assign cmp.gt   = ~wide[q16div_pkg::WordWidth] && (diff != '0);

endmodule

`default_nettype wire

FILE: rtl/q16_16_signed_divider_core.sv
// Top level of the signed Q16.16 restoring divider.
//
// Usage: present a dividend and divisor on the input channel with in_valid;
// a transfer happens when in_valid and in_ready are both high. Each transfer
// produces exactly one result on the output channel (quotient and
// divide_by_zero), which transfers when out_valid and out_ready are high.
// The quotient is truncated toward zero; overflow wraps modulo 2^32.
// A zero divisor returns 0x80000000 with divide_by_zero set.
//
// After an input transfer the sequencer steps through ST_MAG_NUM and
// ST_MAG_DEN (operand magnitudes), ST_NORM (divisor normalization shifts),
// ST_GUARD, ST_DIV (quotient-bit steps) and ST_SIGN, then returns to idle;
// a zero divisor goes straight to ST_SIGN. Every step goes through one
// shared 32-bit subtractor; in_ready is high only while the sequencer is idle.
//
// The result sits in an output register, so a new item may transfer in while
// the previous result waits. If the receiver stalls, the sequencer holds in
// its final step until the output register frees up.
// Reset (rst, synchronous, active high) returns to idle and drops out_valid.
`default_nettype none

module q16_16_signed_divider_core (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  signed [31:0] dividend,
  input  wire  signed [31:0] divisor,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [31:0] quotient,
  output logic               divide_by_zero
);

  q16div_pkg::state_t state, state_next;

  // Working registers of the datapath.
  q16div_pkg::word_t num, num_next;   // raw dividend bits
  q16div_pkg::word_t den, den_next;   // raw divisor bits
  q16div_pkg::word_t rem, rem_next;   // running remainder magnitude
  q16div_pkg::word_t dvs, dvs_next;   // shifted divisor magnitude
  q16div_pkg::word_t quo, quo_next;   // quotient magnitude
  q16div_pkg::word_t weight, weight_next;
  logic [q16div_pkg::GuardWidth-1:0] guard, guard_next;
  logic dz, dz_next;

  // Output register.
  q16div_pkg::word_t res, res_next;
  logic res_dz, res_dz_next;
  logic out_valid_next;

  // Shared unit operands and results.
  q16div_pkg::word_t alu_a, alu_b, alu_diff;
  q16div_pkg::cmp_t  alu_cmp;

  logic out_free;
  q16div_pkg::word_t rem_step;

  q16div_unit u_unit (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .cmp  (alu_cmp)
  );

  assign out_free       = ~out_valid | out_ready;
  assign in_ready       = (state == q16div_pkg::ST_IDLE);
  assign quotient       = $signed(res);
  assign divide_by_zero = res_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= q16div_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    num    <= num_next;
    den    <= den_next;
    rem    <= rem_next;
    dvs    <= dvs_next;
    quo    <= quo_next;
    weight <= weight_next;
    guard  <= guard_next;
    dz     <= dz_next;
    res    <= res_next;
    res_dz <= res_dz_next;
  end

  always_comb begin
    state_next     = state;
    num_next       = num;
    den_next       = den;
    rem_next       = rem;
    dvs_next       = dvs;
    quo_next       = quo;
    weight_next    = weight;
    guard_next     = guard;
    dz_next        = dz;
    res_next       = res;
    res_dz_next    = res_dz;
    out_valid_next = out_valid & ~out_ready;
    alu_a          = rem;
    alu_b          = dvs;
    rem_step       = rem;

    unique case (state)
      q16div_pkg::ST_IDLE: begin
        if (in_valid) begin
          num_next    = $unsigned(dividend);
          den_next    = $unsigned(divisor);
          quo_next    = '0;
          weight_next = q16div_pkg::OneWeight;
          guard_next  = '0;
          // A zero divisor skips the arithmetic entirely.
          if (divisor == '0) begin
            dz_next    = 1'b1;
            state_next = q16div_pkg::ST_SIGN;
          end else begin
            dz_next    = 1'b0;
            state_next = q16div_pkg::ST_MAG_NUM;
          end
        end
      end

      q16div_pkg::ST_MAG_NUM: begin
        alu_a      = '0;
        alu_b      = num;
        rem_next   = (num[q16div_pkg::WordWidth-1]) ? alu_diff : num;
        state_next = q16div_pkg::ST_MAG_DEN;
      end

      q16div_pkg::ST_MAG_DEN: begin
        alu_a      = '0;
        alu_b      = den;
        dvs_next   = (den[q16div_pkg::WordWidth-1]) ? alu_diff : den;
        state_next = q16div_pkg::ST_NORM;
      end

      q16div_pkg::ST_NORM: begin
        // Shift the divisor up while it is below the remainder.
        if (alu_cmp.gt && !guard[q16div_pkg::GuardWidth-1]) begin
          dvs_next    = {dvs[q16div_pkg::WordWidth-2:0], 1'b0};
          weight_next = {weight[q16div_pkg::WordWidth-2:0], 1'b0};
          guard_next  = guard + 1'b1;
        end else begin
          state_next = q16div_pkg::ST_GUARD;
        end
      end

      q16div_pkg::ST_GUARD: begin
        // Divisor with its top bit set: one step before shifting back down.
        if (dvs[q16div_pkg::WordWidth-1]) begin
          if (alu_cmp.ge) begin
            quo_next = quo | weight;
            rem_next = alu_diff;
          end
          dvs_next    = {1'b0, dvs[q16div_pkg::WordWidth-1:1]};
          weight_next = {1'b0, weight[q16div_pkg::WordWidth-1:1]};
        end
        state_next = q16div_pkg::ST_DIV;
      end

      q16div_pkg::ST_DIV: begin
        if (weight == '0 || rem == '0) begin
          state_next = q16div_pkg::ST_SIGN;
        end else begin
          if (alu_cmp.ge) begin
            quo_next = quo | weight;
            rem_step = alu_diff;
          end
          rem_next    = {rem_step[q16div_pkg::WordWidth-2:0], 1'b0};
          weight_next = {1'b0, weight[q16div_pkg::WordWidth-1:1]};
        end
      end

      q16div_pkg::ST_SIGN: begin
        alu_a = '0;
        alu_b = quo;
        // Hold here until the output register can take the result.
        if (out_free) begin
          if (dz) begin
            res_next = q16div_pkg::TopBit;
          end else if ((num[q16div_pkg::WordWidth-1] ^ den[q16div_pkg::WordWidth-1])) begin
            res_next = alu_diff;
          end else begin
            res_next = quo;
          end
          res_dz_next    = dz;
          out_valid_next = 1'b1;
          state_next     = q16div_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = q16div_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // A zero-divisor result always carries the minimum value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> quotient == $signed(q16div_pkg::TopBit))
    else $error("zero divisor result is not the minimum value");

  // The divisor magnitude never reaches zero while quotient bits are formed.
  assert property (@(posedge clk) disable iff (rst)
    state == q16div_pkg::ST_DIV |-> dvs != '0)
    else $error("divisor magnitude is zero during division");

  // After an input transfer the sequencer is busy.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while sequencer busy");

  // A pending result is never overwritten before it transfers.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quotient))
    else $error("pending result dropped or changed");
`endif

endmodule

`default_nettype wire

FILE: test/q16_16_signed_divider_core_tb.sv
// Self-checking testbench for the Q16.16 signed restoring divider core.
`default_nettype none

module q16_16_signed_divider_core_tb;

  // One expected output transfer, plus the operands that caused it for messages.
  typedef struct {
    q16div_pkg::word_t num;
    q16div_pkg::word_t den;
    q16div_pkg::word_t quo;
    logic              dbz;
  } div_result_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  q16div_pkg::word_t dividend = '0;
  q16div_pkg::word_t divisor = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  logic  signed [31:0] quotient;
  logic  divide_by_zero;

  // Idle chances in percent for each side; the test tasks switch these.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  // A long receiver hold-off is requested by bumping hold_id; the receiver
  // process owns the countdown.
  int unsigned hold_id = 0;
  int unsigned hold_len = 0;

  int unsigned errors = 0;
  div_result_t pending_quotients[$];

  q16_16_signed_divider_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .dividend       (dividend),
    .divisor        (divisor),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .quotient       (quotient),
    .divide_by_zero (divide_by_zero)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bail out if the run hangs anywhere.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Bit-exact quotient of the restoring divider, on 32-bit wrapping words.
  function automatic q16div_pkg::word_t q16_quotient(q16div_pkg::word_t num,
                                                     q16div_pkg::word_t den);
    q16div_pkg::word_t rem;
    q16div_pkg::word_t dvs;
    q16div_pkg::word_t quo;
    q16div_pkg::word_t weight;
    int unsigned       shifts;
    if (den == '0) begin
      return q16div_pkg::TopBit;
    end
    rem    = num[31] ? q16div_pkg::word_t'(~num + 32'd1) : num;
    dvs    = den[31] ? q16div_pkg::word_t'(~den + 32'd1) : den;
    quo    = '0;
    weight = q16div_pkg::OneWeight;
    shifts = 0;
    // Normalize: scale the divisor up to the remainder; the weight may fall off.
    while (dvs < rem && shifts < 64) begin
      dvs    = dvs << 1;
      weight = weight << 1;
      shifts++;
    end
    // Guarded step when the scaled divisor reached the top bit.
    if (dvs[31]) begin
      if (rem >= dvs) begin
        quo = quo | weight;
        rem = rem - dvs;
      end
      dvs    = dvs >> 1;
      weight = weight >> 1;
    end
    // One quotient bit per step.
    while (weight != '0 && rem != '0) begin
      if (rem >= dvs) begin
        quo = quo | weight;
        rem = rem - dvs;
      end
      rem    = rem << 1;
      weight = weight >> 1;
    end
    if (num[31] ^ den[31]) begin
      quo = ~quo + 32'd1;
    end
    return quo;
  endfunction

  // Offer one divide and hold it until the transfer; queue its expected result.
  task automatic send_divide(input q16div_pkg::word_t num, input q16div_pkg::word_t den);
    div_result_t exp_item;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    dividend <= num;
    divisor  <= den;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    exp_item.num = num;
    exp_item.den = den;
    exp_item.quo = q16_quotient(num, den);
    exp_item.dbz = (den == '0);
    pending_quotients.push_back(exp_item);
  endtask

  // Operand mix: full-range words, small values, scaled magnitudes, whole
  // numbers and the corner words.
  function automatic q16div_pkg::word_t random_operand();
    q16div_pkg::word_t v;
    case ($urandom_range(5))
      0, 1: v = $urandom;
      2: v = $urandom_range(32'h0003_FFFF);
      3: v = $urandom >> $urandom_range(31);
      4: v = q16div_pkg::word_t'($urandom_range(32767)) << 16;
      default: begin
        case ($urandom_range(6))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          3: v = 32'h0000_0001;
          4: v = 32'hFFFF_FFFF;
          5: v = q16div_pkg::OneWeight;
          default: v = 32'hFFFF_0000;
        endcase
      end
    endcase
    if ($urandom_range(1) == 1) begin
      v = ~v + 32'd1;
    end
    return v;
  endfunction

  task automatic send_random_divides(input int unsigned count);
    q16div_pkg::word_t num;
    q16div_pkg::word_t den;
    for (int unsigned i = 0; i < count; i++) begin
      num = random_operand();
      // Hit the zero-divisor path now and then on top of what the mix gives.
      den = ($urandom_range(99) < 3) ? q16div_pkg::word_t'(0) : random_operand();
      send_divide(num, den);
    end
  endtask

  // Receiver: check each output transfer against the oldest expectation,
  // then decide out_ready for the next cycle.
  initial begin : result_checker
    div_result_t exp_item;
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_quotients.size() == 0) begin
          $display("%0t unexpected result: expected none actual quotient %h flag %b",
                   $time, quotient, divide_by_zero);
          errors++;
        end else begin
          exp_item = pending_quotients.pop_front();
          if (quotient !== exp_item.quo) begin
            $display("%0t quotient mismatch (%h / %h): expected %h actual %h",
                     $time, exp_item.num, exp_item.den, exp_item.quo, quotient);
            errors++;
          end
          if (divide_by_zero !== exp_item.dbz) begin
            $display("%0t divide_by_zero mismatch (%h / %h): expected %b actual %b",
                     $time, exp_item.num, exp_item.den, exp_item.dbz, divide_by_zero);
            errors++;
          end
        end
      end
      // Start a requested hold-off, count it down, else stall at random.
      if (hold_seen != hold_id) begin
        hold_seen = hold_id;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Corners: unit values, extremes, zero divisor, sign mixes, the weight
  // shifting out during normalization and the guarded top-bit step.
  task automatic test_directed_corners();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_divide(32'h0000_0000, 32'h0001_0000);
    send_divide(32'h0001_0000, 32'h0001_0000);
    send_divide(32'hFFFF_0000, 32'h0001_0000);
    send_divide(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_divide(32'h8000_0000, 32'h8000_0000);
    send_divide(32'h8000_0000, 32'h0000_0001);
    send_divide(32'h7FFF_FFFF, 32'h0000_0001);
    send_divide(32'h0000_0001, 32'h7FFF_FFFF);
    send_divide(32'h0000_0001, 32'h8000_0000);
    send_divide(32'h0000_0005, 32'h0000_0000);
    send_divide(32'h8000_0000, 32'h0000_0000);
    send_divide(32'h0000_0000, 32'h0000_0000);
    send_divide(32'hFFFF_FFFB, 32'hFFFF_FFFD);
    send_divide(32'h0003_8000, 32'hFFFE_0000);
    send_divide(32'h8000_0000, 32'hFFFF_FFFF);
    send_divide(32'h0001_0000, 32'hFFFF_FFFF);
    send_divide(32'h7F00_0000, 32'h6000_0000);
    send_divide(32'h7FFF_FFFF, 32'hC000_0001);
    send_divide(32'h0000_FFFF, 32'h0001_0000);
    send_divide(32'h8000_0000, 32'h7FFF_FFFF);
  endtask

  task automatic test_random_slow_receiver();
    tx_idle_pct = 12;
    rx_idle_pct = 60;
    send_random_divides(620);
  endtask

  task automatic test_random_slow_sender();
    tx_idle_pct = 60;
    rx_idle_pct = 12;
    send_random_divides(620);
  endtask

  task automatic test_random_full_rate();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_divides(560);
  endtask

  // Hold the receiver off long enough for the output register and the
  // sequencer to fill, while the sender keeps offering back to back.
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_len = 400;
    hold_id++;
    send_random_divides(30);
  endtask

  initial begin : run_tests
    int unsigned waited;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_corners();
    test_random_slow_receiver();
    test_random_slow_sender();
    test_output_backpressure();
    test_random_full_rate();

    // Drop valid, drain outstanding results, then allow for the worst latency.
    in_valid <= 1'b0;
    waited = 0;
    while (pending_quotients.size() != 0 && waited < 200_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (80) @(posedge clk);
    if (pending_quotients.size() != 0) begin
      $display("%0t missing results: expected %0d more actual 0",
               $time, pending_quotients.size());
      errors++;
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/q16div_pkg.sv
rtl/q16div_unit.sv
rtl/q16_16_signed_divider_core.sv
test/q16_16_signed_divider_core_tb.sv
